>>> sv/dwr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwr_pkg
// Shared constants, command and status codes, and cell control types for the
// deque with reverse flag.
// ----------------------------------------------------------------------------
package dwr_pkg;

    localparam int DEPTH    = 16;
    localparam int WORD_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TOGGLE     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_RIGHT,
        CELL_SHIFT_LEFT,
        CELL_PUSH_TAIL,
        CELL_POP_TAIL
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        word_t    word;
    } row_ctrl_t;

    typedef struct packed {
        word_t head_word;
        word_t tail_word;
    } row_view_t;

endpackage
`default_nettype wire

>>> sv/dwr_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwr_cmd_if
// Command channel: valid/ready handshake carrying a command and a word.
// ----------------------------------------------------------------------------
interface dwr_cmd_if
    import dwr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    word_t             value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

>>> sv/dwr_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwr_res_if
// Result channel: valid/ready handshake carrying status, ends and count.
// ----------------------------------------------------------------------------
interface dwr_res_if
    import dwr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    word_t                front_value;
    word_t                back_value;
    logic                 is_empty;
    logic [CNT_W-1:0]     count;

    modport source (output valid, output status, output front_value, output back_value,
                    output is_empty, output count, input ready);
    modport sink   (input valid, input status, input front_value, input back_value,
                    input is_empty, input count, output ready);
endinterface
`default_nettype wire

>>> sv/deque_with_reverse_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deque_with_reverse_unit
// Bounded deque of 32-bit signed words with a reverse flag.
// ----------------------------------------------------------------------------
// Channels: cmd takes one command word (push back/front, pop back/front,
// toggle reverse, query) with a value; res returns one result word per
// command: status, logical front and back words (all ones when empty),
// empty flag and count.
// Storage is a row of DEPTH cells, cell 0 the physical head. A head push
// shifts the whole row right, a head pop shifts it left; tail operations
// touch only the boundary cell. The row updates at the edge that accepts a command.
// The result is registered in the result stage, then in the output register.
// Throughput: one command per cycle while res takes results; the row update
// and result stage overlap; a new command waits only on the output register.
// When res stalls, one result waits in the result stage and the output
// register holds; cmd ready drops until the output register drains.
// Reset empties all cells (valid bits only), clears count and reverse flag.
// No clearing pass is needed.
// ----------------------------------------------------------------------------
module deque_with_reverse_unit
    import dwr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dwr_cmd_if.sink    cmd,
    dwr_res_if.source  res
);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                rev_reg;
    logic                rev_next;
    logic                pend_reg;
    logic [STATUS_W-1:0] pend_status_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    word_t               out_front_reg;
    word_t               out_back_reg;
    logic                out_empty_reg;
    logic [CNT_W-1:0]    out_count_reg;

    logic                accept;
    logic                out_free;
    logic                capture;
    logic                full;
    logic                empty;
    logic                at_tail;
    logic [STATUS_W-1:0] status;
    cell_op_t            op;
    row_ctrl_t           row_ctrl;
    row_view_t           view;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign out_free = !out_valid_reg || res.ready;
    assign capture  = pend_reg && out_free;
    assign cmd.ready = !pend_reg || capture;
    assign accept   = cmd.valid && cmd.ready;

    always_comb
    begin
        op         = CELL_HOLD;
        status     = ST_DONE;
        count_next = count_reg;
        rev_next   = rev_reg;
        at_tail    = 1'b0;
        case (cmd.command)
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                // logical back is the physical tail unless reversed
                at_tail = (cmd.command == CMD_PUSH_BACK) != rev_reg;
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    op         = at_tail ? CELL_PUSH_TAIL : CELL_SHIFT_RIGHT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_BACK, CMD_POP_FRONT:
            begin
                at_tail = (cmd.command == CMD_POP_BACK) != rev_reg;
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    op         = at_tail ? CELL_POP_TAIL : CELL_SHIFT_LEFT;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_TOGGLE:
            begin
                rev_next = !rev_reg;
            end
            default:
            begin
                status = ST_DONE;
            end
        endcase
    end

    assign row_ctrl.op   = accept ? op : CELL_HOLD;
    assign row_ctrl.word = cmd.value;

    dwr_row u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (row_ctrl),
        .view  (view)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
                rev_reg   <= rev_next;
                pend_reg  <= 1'b1;
            end
            else if (capture)
            begin
                pend_reg <= 1'b0;
            end

            if (capture)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result stage reads the row as the pending command left it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= status;
        end
        if (capture)
        begin
            out_status_reg <= pend_status_reg;
            out_empty_reg  <= empty;
            out_count_reg  <= count_reg;
            if (empty)
            begin
                out_front_reg <= '1;
                out_back_reg  <= '1;
            end
            else if (rev_reg)
            begin
                out_front_reg <= view.tail_word;
                out_back_reg  <= view.head_word;
            end
            else
            begin
                out_front_reg <= view.head_word;
                out_back_reg  <= view.tail_word;
            end
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.front_value = out_front_reg;
    assign res.back_value  = out_back_reg;
    assign res.is_empty    = out_empty_reg;
    assign res.count       = out_count_reg;

endmodule
`default_nettype wire

>>> sv/dwr_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwr_cell
// One storage cell of the deque row: a word and a valid bit, loaded from
// either neighbor or from the push word, cleared on a tail pop, or held.
// ----------------------------------------------------------------------------
module dwr_cell
    import dwr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire row_ctrl_t ctrl,
    input  wire logic      left_valid,
    input  wire word_t     left_word,
    input  wire logic      right_valid,
    input  wire word_t     right_word,
    output logic           valid,
    output word_t          word
);

    logic  valid_reg;
    logic  valid_next;
    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        case (ctrl.op)
            CELL_SHIFT_RIGHT:
            begin
                valid_next = left_valid;
                word_next  = left_word;
            end
            CELL_SHIFT_LEFT:
            begin
                valid_next = right_valid;
                word_next  = right_word;
            end
            CELL_PUSH_TAIL:
            begin
                // first empty cell takes the word
                if (!valid_reg && left_valid)
                begin
                    valid_next = 1'b1;
                    word_next  = ctrl.word;
                end
            end
            CELL_POP_TAIL:
            begin
                // last occupied cell lets go
                if (valid_reg && !right_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule
`default_nettype wire

>>> sv/dwr_row.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwr_row
// Row of deque cells, cell 0 at the physical head. Also picks out the head
// and tail words for the result stage.
// ----------------------------------------------------------------------------
module dwr_row
    import dwr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire row_ctrl_t ctrl,
    output row_view_t      view
);

    logic  cell_valid [DEPTH];
    word_t cell_word  [DEPTH];
    logic  left_valid [DEPTH];
    word_t left_word  [DEPTH];
    logic  right_valid[DEPTH];
    word_t right_word [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                // head cell sees a full left neighbor holding the push word
                assign left_valid[gi] = 1'b1;
                assign left_word[gi]  = ctrl.word;
            end
            else
            begin : g_mid
                assign left_valid[gi] = cell_valid[gi-1];
                assign left_word[gi]  = cell_word[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_valid[gi] = 1'b0;
                assign right_word[gi]  = '0;
            end
            else
            begin : g_inner
                assign right_valid[gi] = cell_valid[gi+1];
                assign right_word[gi]  = cell_word[gi+1];
            end

            dwr_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_valid  (left_valid[gi]),
                .left_word   (left_word[gi]),
                .right_valid (right_valid[gi]),
                .right_word  (right_word[gi]),
                .valid       (cell_valid[gi]),
                .word        (cell_word[gi])
            );
        end
    endgenerate

    // tail is the one occupied cell whose right neighbor is empty
    always_comb
    begin
        view.head_word = cell_word[0];
        view.tail_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_valid[i] && !right_valid[i])
            begin
                view.tail_word = view.tail_word | cell_word[i];
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/dwr_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwr_chk
// Port-level checks on the deque result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dwr_chk
    import dwr_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                res_valid,
    input wire logic                res_ready,
    input wire logic [STATUS_W-1:0] status,
    input wire word_t               front_value,
    input wire word_t               back_value,
    input wire logic                is_empty,
    input wire logic [CNT_W-1:0]    count
);

    // empty flag agrees with the count
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

    // an empty deque reports all ones at both ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && is_empty) |-> ((front_value == '1) && (back_value == '1)))
    else $error("empty deque shows a word");

    // a single word is both front and back
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (count == CNT_W'(1))) |-> (front_value == back_value))
    else $error("single word differs at the two ends");

    // a refused push only happens at full, a refused pop only at empty
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (((status != ST_FULL) || (count == CNT_W'(DEPTH)))
                       && ((status != ST_EMPTY) || is_empty)))
    else $error("refusal with room to spare");

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(count) && $stable(status)
                                      && $stable(front_value) && $stable(back_value)))
    else $error("stalled result word changed");

endmodule

bind deque_with_reverse_unit dwr_chk u_dwr_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .status      (res.status),
    .front_value (res.front_value),
    .back_value  (res.back_value),
    .is_empty    (res.is_empty),
    .count       (res.count)
);
`default_nettype wire
